// ----- rtl/core/sorted_list_intersection_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_list_intersection_macros.svh
// Assertion macros for the sorted list intersection block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INTERSECTION_MACROS_SVH
`define SORTED_LIST_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted_list_intersection: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_list_intersection: assertion failed");
`else
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list intersection block.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int SLI_MAX_LISTS = 8;
	localparam int SLI_MAX_LEN   = 64;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_RUN    = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  list_id;
		logic [31:0] value;
		logic [3:0]  list_count;
	} req_item_t;

	typedef struct packed {
		logic [31:0] common_value;
		logic        last;
		logic        empty_res;
	} rsp_item_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_APPEND,
		DP_START,
		DP_SORT,
		DP_KEY_RD,
		DP_KEY_CAP,
		DP_LAST_RD,
		DP_LAST_CHK,
		DP_WALK,
		DP_NEXT_K,
		DP_EMIT,
		DP_FINAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic sort_done;
		logic no_work;
		logic n_one;
		logic stop;
		logic pos_end;
		logic walk_lt;
		logic walk_eq;
		logic walk_end;
		logic m_last;
		logic k_last;
		logic out_free;
		logic pend_vld;
	} dp_stat_t;

endpackage

// ----- rtl/core/sorted_list_intersection.sv -----
// ----------------------------------------------------------------------------
// sorted_list_intersection
// Intersection of ascending id lists with a sequencer and a list datapath.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  req      | req_valid/req_ready  | action, list_id, value, list_count
//  rsp      | rsp_valid/rsp_ready  | common_value, last, empty_res
//
// Clear and append transactions are done in the idle state. A run sorts the lists
// by length and checks them, then per key of the shortest list reads the key, per
// further list searched reads its last entry and steps the cursor, and emits a match,
// paced by the single read port of the list store; a final step closes the run.
// Reset empties all lists; the list store itself is not cleared.
// A stalled rsp holds the run in place; req is taken only between runs.
// ----------------------------------------------------------------------------
`include "sorted_list_intersection_macros.svh"

module sorted_list_intersection
	import sli_pkg::*;
#(
	parameter int MAX_LISTS = SLI_MAX_LISTS,
	parameter int MAX_LEN   = SLI_MAX_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_action(req.action),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sli_dp #(
		.MAX_LISTS(MAX_LISTS),
		.MAX_LEN  (MAX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	`SLI_ASSERT_NXT(a_run_blocks_req, clk, arst_n,
		req_valid && req_ready && (req.action == ACT_RUN), !req_ready)
	`SLI_ASSERT_IMP(a_empty_is_last, clk, arst_n, rsp_valid && rsp.empty_res,
		rsp.last && (rsp.common_value == 32'd0))
	`SLI_ASSERT_IMP(a_idle_no_pending, clk, arst_n, req_ready, !stat.pend_vld)

endmodule

// ----- rtl/core/sli_ram.sv -----
// ----------------------------------------------------------------------------
// sli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/sli_ctrl.sv -----
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer of the intersection: decodes items and steps the datapath.
// ----------------------------------------------------------------------------
module sli_ctrl
	import sli_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic [1:0] req_action,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output dp_cmd_t   cmd
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_SORT     = 11'b00000000010,
		ST_CHECK    = 11'b00000000100,
		ST_KEY_RD   = 11'b00000001000,
		ST_KEY_CAP  = 11'b00000010000,
		ST_LAST_RD  = 11'b00000100000,
		ST_LAST_CHK = 11'b00001000000,
		ST_WALK     = 11'b00010000000,
		ST_NEXT_K   = 11'b00100000000,
		ST_EMIT     = 11'b01000000000,
		ST_FINAL    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	dp_op_t op;

	always_comb begin
		state_d = state_q;
		op      = DP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req_action)
						ACT_CLEAR:  op = DP_CLEAR;
						ACT_APPEND: op = DP_APPEND;
						ACT_RUN: begin
							op      = DP_START;
							state_d = ST_SORT;
						end
						default: op = DP_NOP;
					endcase
				end
			end
			ST_SORT: begin
				if (stat.sort_done) state_d = ST_CHECK;
				else op = DP_SORT;
			end
			ST_CHECK: state_d = stat.no_work ? ST_FINAL : ST_KEY_RD;
			ST_KEY_RD: begin
				op      = DP_KEY_RD;
				state_d = ST_KEY_CAP;
			end
			ST_KEY_CAP: begin
				op      = DP_KEY_CAP;
				state_d = stat.n_one ? ST_EMIT : ST_LAST_RD;
			end
			ST_LAST_RD: begin
				op      = DP_LAST_RD;
				state_d = ST_LAST_CHK;
			end
			ST_LAST_CHK: begin
				op = DP_LAST_CHK;
				priority if (stat.stop) state_d = ST_FINAL;
				else if (stat.pos_end) state_d = ST_NEXT_K;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				op = DP_WALK;
				priority if (stat.walk_lt) state_d = stat.walk_end ? ST_NEXT_K : ST_WALK;
				else if (stat.walk_eq) state_d = stat.m_last ? ST_EMIT : ST_LAST_RD;
				else state_d = ST_NEXT_K;
			end
			ST_NEXT_K: begin
				op      = DP_NEXT_K;
				state_d = stat.k_last ? ST_FINAL : ST_KEY_RD;
			end
			ST_EMIT: begin
				// The held result leaves only when the output register can take it.
				if (!stat.pend_vld || stat.out_free) begin
					op      = DP_EMIT;
					state_d = ST_NEXT_K;
				end
			end
			ST_FINAL: begin
				if (stat.out_free) begin
					op      = DP_FINAL;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign cmd.op    = op;

endmodule

// ----- rtl/core/sli_dp.sv -----
// ----------------------------------------------------------------------------
// sli_dp
// Datapath: list store, lengths, length order, cursors and result register.
// ----------------------------------------------------------------------------
module sli_dp
	import sli_pkg::*;
#(
	parameter int MAX_LISTS = SLI_MAX_LISTS,
	parameter int MAX_LEN   = SLI_MAX_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  req_item_t req,
	output dp_stat_t  stat,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int LID_W  = $clog2(MAX_LISTS);
	localparam int CNT_W  = $clog2(MAX_LISTS + 1);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int DEPTH  = MAX_LISTS * MAX_LEN;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [LEN_W-1:0] len_q   [MAX_LISTS];
	logic [LID_W-1:0] order_q [MAX_LISTS];
	logic [LEN_W-1:0] cur_q   [MAX_LISTS];

	logic [CNT_W-1:0] n_q, si_q, sj_q, m_q;
	logic             empty_run_q;
	logic [LEN_W-1:0] k_q, pos_q;
	logic [31:0]      key_q, pend_q;
	logic             pend_vld_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic [LID_W-1:0]  app_id, order_a, order_b, lst, first;
	logic              app_ok;
	logic [LEN_W-1:0]  app_len, llen, slen, pos_next;
	logic [CNT_W-1:0]  n_in;
	logic              any_zero;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0]       rdata;
	logic              out_free, swap;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [LID_W-1:0] l,
		input logic [LEN_W-1:0] idx);
		addr_of = ADDR_W'(ADDR_W'(l) * ADDR_W'(MAX_LEN) + ADDR_W'(idx));
	endfunction

	// Append decode
	assign app_id  = LID_W'(req.list_id);
	assign app_len = len_q[app_id];
	assign app_ok  = (32'(req.list_id) < MAX_LISTS) && (32'(app_len) < MAX_LEN);

	// Run start: list count saturates, a zero count or any empty list makes the run empty.
	always_comb begin
		n_in     = (32'(req.list_count) > MAX_LISTS) ? CNT_W'(MAX_LISTS)
			: CNT_W'(req.list_count);
		any_zero = (n_in == '0);
		for (int x = 0; x < MAX_LISTS; x++) begin
			if ((CNT_W'(x) < n_in) && (len_q[x] == '0)) any_zero = 1'b1;
		end
	end

	assign order_a  = order_q[si_q[LID_W-1:0]];
	assign order_b  = order_q[sj_q[LID_W-1:0]];
	assign swap     = len_q[order_a] > len_q[order_b];
	assign first    = order_q[0];
	assign slen     = len_q[first];
	assign lst      = order_q[m_q[LID_W-1:0]];
	assign llen     = len_q[lst];
	assign pos_next = pos_q + LEN_W'(1);
	assign out_free = !rsp_valid_q || rsp_ready;

	assign we    = (cmd.op == DP_APPEND) && app_ok;
	assign waddr = addr_of(app_id, app_len);

	always_comb begin
		unique case (cmd.op)
			DP_KEY_RD:   raddr = addr_of(first, k_q);
			DP_LAST_RD:  raddr = addr_of(lst, llen - LEN_W'(1));
			DP_LAST_CHK: raddr = addr_of(lst, cur_q[lst]);
			DP_WALK:     raddr = addr_of(lst, pos_next);
			default:     raddr = '0;
		endcase
	end

	sli_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		stat.sort_done = ((CNT_W + 1)'(si_q) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(n_q);
		stat.no_work   = empty_run_q || (slen == '0);
		stat.n_one     = (n_q == CNT_W'(1));
		stat.stop      = key_q > rdata;
		stat.pos_end   = cur_q[lst] >= llen;
		stat.walk_lt   = rdata < key_q;
		stat.walk_eq   = rdata == key_q;
		stat.walk_end  = pos_next >= llen;
		stat.m_last    = ((CNT_W + 1)'(m_q) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(n_q);
		stat.k_last    = ((LEN_W + 1)'(k_q) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(slen);
		stat.out_free  = out_free;
		stat.pend_vld  = pend_vld_q;
	end

	// Lengths, length order and cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int x = 0; x < MAX_LISTS; x++) begin
				len_q[x]   <= '0;
				order_q[x] <= LID_W'(x);
				cur_q[x]   <= '0;
			end
		end else begin
			unique case (cmd.op)
				DP_CLEAR: begin
					for (int x = 0; x < MAX_LISTS; x++) len_q[x] <= '0;
				end
				DP_APPEND: begin
					if (app_ok) len_q[app_id] <= app_len + LEN_W'(1);
				end
				DP_START: begin
					for (int x = 0; x < MAX_LISTS; x++) begin
						order_q[x] <= LID_W'(x);
						cur_q[x]   <= '0;
					end
				end
				DP_SORT: begin
					// Exchange only on strictly greater length.
					if (swap) begin
						order_q[si_q[LID_W-1:0]] <= order_b;
						order_q[sj_q[LID_W-1:0]] <= order_a;
					end
				end
				DP_WALK: begin
					if (!stat.walk_lt && stat.walk_eq) cur_q[lst] <= pos_q;
				end
				default: ;
			endcase
		end
	end

	// Run counters and key
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_START: begin
				n_q         <= n_in;
				empty_run_q <= any_zero;
				si_q        <= '0;
				sj_q        <= CNT_W'(1);
				k_q         <= '0;
			end
			DP_SORT: begin
				if (((CNT_W + 1)'(sj_q) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(n_q)) begin
					si_q <= si_q + CNT_W'(1);
					sj_q <= si_q + CNT_W'(2);
				end else begin
					sj_q <= sj_q + CNT_W'(1);
				end
			end
			DP_KEY_RD:   m_q   <= CNT_W'(1);
			DP_KEY_CAP:  key_q <= rdata;
			DP_LAST_CHK: pos_q <= cur_q[lst];
			DP_WALK: begin
				if (stat.walk_lt) pos_q <= pos_next;
				else if (stat.walk_eq) m_q <= m_q + CNT_W'(1);
			end
			DP_NEXT_K:   k_q <= k_q + LEN_W'(1);
			default: ;
		endcase
	end

	// A match is held back one step so that the final one can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_EMIT) begin
				pend_vld_q <= 1'b1;
				if (pend_vld_q) rsp_valid_q <= 1'b1;
				else if (rsp_ready) rsp_valid_q <= 1'b0;
			end else if (cmd.op == DP_FINAL) begin
				pend_vld_q  <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_EMIT) begin
			pend_q <= key_q;
			if (pend_vld_q) begin
				rsp_q.common_value <= pend_q;
				rsp_q.last         <= 1'b0;
				rsp_q.empty_res    <= 1'b0;
			end
		end else if (cmd.op == DP_FINAL) begin
			rsp_q.common_value <= pend_vld_q ? pend_q : 32'd0;
			rsp_q.last         <= 1'b1;
			rsp_q.empty_res    <= !pend_vld_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- tb/sorted_list_intersection_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_list_intersection_tb
// Drives clear, append and run transactions into the list intersection block
// with bursty input and a stalling output, predicts each run's results and
// compares them with the results as they come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_intersection_tb;
	import sli_pkg::*;

	localparam int NLISTS = SLI_MAX_LISTS;
	localparam int LEN = SLI_MAX_LEN;
	localparam int IDLE_LIMIT = 200000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_item_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp;

	sorted_list_intersection dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predictor state.
	logic [31:0] lists [NLISTS][LEN];
	int unsigned lens [NLISTS];
	int unsigned cursor [NLISTS];
	int unsigned order [NLISTS];

	req_item_t pending [$];
	rsp_item_t expected_results [$];
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	bit hold_for_drain = 0;
	int idle_cycles = 0;
	int stall_phase = 0;
	bit stim_done = 0;

	function automatic void add_pending(input req_item_t it);
		pending.insert(pending.size(), it);
	endfunction

	function automatic void add_expected(input rsp_item_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Model of the block: updates the lists and queues the results of a run.
	task automatic predict(input req_item_t it);
		int unsigned n, slen, shortest, key, lst, pos, tmp, cnt;
		bit found, stop;
		rsp_item_t r;
		cnt = 0;
		case (it.action)
			ACT_CLEAR: for (int i = 0; i < NLISTS; i++) lens[i] = 0;
			ACT_APPEND: if (lens[it.list_id] < LEN) begin
				lists[it.list_id][lens[it.list_id]] = it.value;
				lens[it.list_id]++;
			end
			ACT_RUN: begin
				for (int i = 0; i < NLISTS; i++) cursor[i] = 0;
				n = (it.list_count > NLISTS) ? NLISTS : it.list_count;
				if (n > 0) begin
					for (int i = 0; i < n; i++) order[i] = i;
					for (int i = 0; i + 1 < n; i++)
						for (int j = i + 1; j < n; j++)
							if (lens[order[i]] > lens[order[j]]) begin
								tmp = order[i];
								order[i] = order[j];
								order[j] = tmp;
							end
					shortest = order[0];
					slen = lens[shortest];
					for (int i = 0; i < n; i++) if (lens[i] == 0) slen = 0;
					for (int k = 0; k < slen; k++) begin
						key = lists[shortest][k];
						found = 1;
						stop = 0;
						for (int m = 1; m < n; m++) begin
							lst = order[m];
							pos = cursor[lst];
							if (key > lists[lst][lens[lst] - 1]) begin
								stop = 1;
								break;
							end
							while (pos < lens[lst] && lists[lst][pos] < key) pos++;
							if (pos >= lens[lst] || lists[lst][pos] != key) begin
								found = 0;
								break;
							end
							cursor[lst] = pos;
						end
						if (stop) break;
						if (found && cnt < LEN) begin
							r.common_value = key;
							r.last = 0;
							r.empty_res = 0;
							add_expected(r);
							cnt++;
						end
					end
				end
				if (cnt == 0) begin
					r.common_value = '0;
					r.last = 1;
					r.empty_res = 1;
					add_expected(r);
				end else begin
					expected_results[$].last = 1;
				end
			end
			default: ;
		endcase
	endtask

	function automatic req_item_t make_item(logic [1:0] a, int id, logic [31:0] v, int n);
		req_item_t it;
		it.action = a;
		it.list_id = id[2:0];
		it.value = v;
		it.list_count = n[3:0];
		return it;
	endfunction

	// Queues an ascending list of the given length built around a shared pool.
	task automatic queue_list(int id, int len, int unsigned stride, int unsigned base);
		int unsigned v;
		v = base;
		for (int i = 0; i < len; i++) begin
			v = v + $urandom_range(1, stride);
			add_pending(make_item(ACT_APPEND, id, v, 0));
		end
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 0;
			req <= '0;
		end else if (req_valid && !req_ready) begin
			// Hold the transaction until it is taken.
		end else begin
			if (req_valid && req_ready) predict(req);
			if (hold_for_drain && expected_results.size() == 0)
				hold_for_drain <= 0;
			if (pending.size() != 0 && !hold_for_drain
			    && (gap_left == 0 || burst_left != 0)) begin
				req_valid <= 1;
				req <= pending.pop_front();
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= $urandom_range(0, 4);
				end
			end else begin
				req_valid <= 0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end
		end
	end

	// Receiver stall pattern and result check.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 64;
			rsp_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h", $time, rsp);
					errors++;
				end else begin
					if (rsp !== expected_results[0]) begin
						$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
						         expected_results[0].common_value, expected_results[0].last,
						         expected_results[0].empty_res,
						         rsp.common_value, rsp.last, rsp.empty_res);
						errors++;
					end
					void'(expected_results.pop_front());
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
			$display("sorted_list_intersection_tb: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned shared;
		int n, len;
		for (int i = 0; i < NLISTS; i++) begin
			lens[i] = 0;
			cursor[i] = 0;
			order[i] = i;
		end
		// Directed: empty runs, extremes, single list, duplicates, overflow, full list.
		add_pending(make_item(ACT_RUN, 0, 0, 0));
		add_pending(make_item(ACT_RUN, 0, 0, 1));
		add_pending(make_item(ACT_APPEND, 0, 32'h0, 0));
		add_pending(make_item(ACT_APPEND, 0, 32'h5, 0));
		add_pending(make_item(ACT_APPEND, 0, 32'h5, 0));
		add_pending(make_item(ACT_APPEND, 0, 32'hFFFF_FFFF, 0));
		add_pending(make_item(ACT_RUN, 7, 32'hFFFF_FFFF, 1));
		add_pending(make_item(ACT_APPEND, 1, 32'h5, 0));
		add_pending(make_item(ACT_APPEND, 1, 32'hFFFF_FFFF, 0));
		add_pending(make_item(ACT_APPEND, 2, 32'h5, 0));
		add_pending(make_item(ACT_APPEND, 2, 32'h6, 0));
		add_pending(make_item(ACT_RUN, 0, 0, 2));
		add_pending(make_item(ACT_RUN, 0, 0, 3));
		add_pending(make_item(ACT_RUN, 0, 0, 15));
		add_pending(make_item(ACT_APPEND, 3, 32'h1, 0));
		add_pending(make_item(ACT_RUN, 0, 0, 4));
		add_pending(make_item(ACT_UNUSED, 5, 32'hAAAA_5555, 9));
		add_pending(make_item(ACT_CLEAR, 0, 0, 0));
		// A full list with one overflowing append, then a run of that list alone.
		queue_list(0, LEN + 1, 3, 0);
		add_pending(make_item(ACT_RUN, 0, 0, 1));
		while (pending.size() != 0) @(posedge clk);
		// The sender holds the following items until every result has come.
		hold_for_drain = 1;
		// Random: mostly well-formed sets of lists sharing values, some noise.
		for (int s = 0; s < 3; s++) begin
			add_pending(make_item(ACT_CLEAR, $urandom_range(0, 7), $urandom, $urandom));
			n = $urandom_range(1, NLISTS);
			shared = $urandom;
			for (int l = 0; l < n; l++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
				queue_list(l, len, ($urandom_range(0, 1) ? 2 : 40), shared[31:4] << 4);
			end
			if ($urandom_range(0, 3) == 0)
				add_pending(make_item(ACT_APPEND, $urandom_range(0, 7), $urandom, 0));
			if ($urandom_range(0, 5) == 0)
				add_pending(make_item(ACT_UNUSED, $urandom_range(0, 7), $urandom, 0));
			add_pending(make_item(ACT_RUN, $urandom_range(0, 7), $urandom,
			                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : n));
			add_pending(make_item(ACT_RUN, 0, 0, $urandom_range(1, n)));
		end
		while (pending.size() != 0 || req_valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		stim_done = 1;
		repeat (200) @(posedge clk);
		if (errors == 0) $display("sorted_list_intersection_tb: done, clean");
		else $display("sorted_list_intersection_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_ram.sv
rtl/core/sli_ctrl.sv
rtl/core/sli_dp.sv
rtl/core/sorted_list_intersection.sv
tb/sorted_list_intersection_tb.sv
